// File: rtl/core/ssdf_pkg.sv
// Shared types and constants of the seven-segment digit formatter.
`default_nettype none

package ssdf_pkg;

   localparam int DIGIT_COUNT   = 8;
   localparam int SMALL_DIGITS  = 3;
   localparam int VALUE_WIDTH   = 32;
   localparam int CONVERT_STEPS = 32;

   typedef logic [3:0] digit_type;

   localparam digit_type CODE_BLANK = 4'd10;
   localparam digit_type CODE_DASH  = 4'd15;

   localparam logic [4:0]  WAIT_WRAP      = 5'd30;
   localparam logic [4:0]  WAIT_HALF      = 5'd15;
   localparam logic [15:0] BLINK_RESET_MS = 16'd500;
   // Smallest magnitude with more than eight decimal digits.
   localparam logic [31:0] NINE_DIGIT_MIN = 32'd100000000;

   typedef enum logic [2:0] {
      KIND_PLAIN        = 3'd0,
      KIND_ERROR        = 3'd1,
      KIND_COUNT_GRAMS  = 3'd2,
      KIND_COUNT        = 3'd3,
      KIND_WAITING      = 3'd4,
      KIND_DASHES       = 3'd5,
      KIND_SIGNED_BLINK = 3'd6,
      KIND_UNDEFINED    = 3'd7
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
   } bcd_ctrl_type;

endpackage

`default_nettype wire

// File: rtl/core/ssdf_channels.sv
// Valid/ready channel interfaces for request and response transactions.
`default_nettype none

interface ssdf_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic signed [31:0] number;
   logic [15:0] count;
   logic [15:0] grams;
   logic        blink_on;
   logic [31:0] now_ms;

   modport source (output valid, kind, number, count, grams, blink_on, now_ms,
                   input ready);
   modport sink   (input valid, kind, number, count, grams, blink_on, now_ms,
                   output ready);
endinterface

interface ssdf_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] position;
   logic [3:0] digit_code;
   logic       last;

   modport source (output valid, position, digit_code, last, input ready);
   modport sink   (input valid, position, digit_code, last, output ready);
endinterface

`default_nettype wire

// File: rtl/core/ssdf_bcd_serial.sv
// Bit-serial binary to BCD converter keeping the low decimal digits.
`default_nettype none

module ssdf_bcd_serial #(
   parameter int DIGITS = 8
) (
   input  wire logic                       clock,
   input  wire ssdf_pkg::bcd_ctrl_type     ctrl,
   input  wire logic [ssdf_pkg::VALUE_WIDTH-1:0] value,
   output logic [DIGITS-1:0][3:0]          digits
);

   logic [ssdf_pkg::VALUE_WIDTH-1:0] shift_ff, shift_in;
   logic [DIGITS-1:0][3:0]           digits_ff, digits_in;
   logic [DIGITS*4-1:0]              adjusted;

   // Add three to each digit of five or more, then shift in the next bit.
   // Carry out of the top digit drops, so the result is the value modulo 10^DIGITS.
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         adjusted[i*4 +: 4] = (digits_ff[i] >= 4'd5) ? digits_ff[i] + 4'd3 : digits_ff[i];
      end
      shift_in  = shift_ff;
      digits_in = digits_ff;
      if (ctrl.load) begin
         shift_in  = value;
         digits_in = '0;
      end else if (ctrl.step) begin
         shift_in  = {shift_ff[ssdf_pkg::VALUE_WIDTH-2:0], 1'b0};
         digits_in = {adjusted[DIGITS*4-2:0], shift_ff[ssdf_pkg::VALUE_WIDTH-1]};
      end
   end

   always_ff @(posedge clock) begin
      shift_ff  <= shift_in;
      digits_ff <= digits_in;
   end

   assign digits = digits_ff;

endmodule

`default_nettype wire

// File: rtl/core/seven_segment_digit_formatter.sv
// Top level of the seven-segment digit formatter.
// A taken request is converted over 32 steps, one bit of the 32-bit value
// entering the BCD shift registers per cycle, before the first digit is offered.
// No new request is taken until 1 accept, 32 conversion steps and 8 digit
// transactions are through; the digit transactions wait while the response side stalls.
// Reset (synchronous, active high): idle, blink interval 500 ms, blink phase,
// last toggle time and waiting counter cleared.
`default_nettype none

module seven_segment_digit_formatter (
   input  wire logic         clock,
   input  wire logic         reset,
   ssdf_req_if.sink          req_bus,
   ssdf_rsp_if.source        rsp_bus,
   input  wire logic         csr_write_enable,
   input  wire logic [15:0]  csr_write_data
);

   // ---------------------------------------------------------------
   // Control and mode state
   // ---------------------------------------------------------------
   ssdf_pkg::state_type state_ff, state_in;
   logic [4:0]  step_ff, step_in;
   logic [2:0]  pos_ff, pos_in;

   logic [15:0] blink_interval_ff, blink_interval_in;
   logic        blink_phase_ff, blink_phase_in;
   logic [31:0] last_toggle_ff, last_toggle_in;
   logic [4:0]  wait_count_ff, wait_count_in;

   // Per-transaction payload held for the emission phase
   ssdf_pkg::kind_type kind_ff, kind_in;
   logic        neg_ff, neg_in;
   logic        big_ff, big_in;          // magnitude needs more than eight digits
   logic        show_ff, show_in;        // signed blink digits visible
   logic        dash_upper_ff, dash_upper_in;

   logic        req_accept;
   logic        rsp_accept;
   ssdf_pkg::bcd_ctrl_type bcd_ctrl;

   logic [31:0] magnitude;
   logic [31:0] elapsed;
   logic [4:0]  wait_next;

   logic [ssdf_pkg::DIGIT_COUNT-1:0][3:0]  num_digits;
   logic [ssdf_pkg::SMALL_DIGITS-1:0][3:0] count_digits;
   logic [ssdf_pkg::SMALL_DIGITS-1:0][3:0] grams_digits;
   logic [3:0]  top_pos;
   ssdf_pkg::digit_type code;

   assign req_accept = req_bus.valid && req_bus.ready;
   assign rsp_accept = rsp_bus.valid && rsp_bus.ready;

   // Magnitude of the signed value; the most negative value maps to 2^31.
   assign magnitude = req_bus.number[31] ? 32'(-req_bus.number) : 32'(req_bus.number);
   assign elapsed   = req_bus.now_ms - last_toggle_ff;
   assign wait_next = (wait_count_ff >= ssdf_pkg::WAIT_WRAP) ? 5'd0 : wait_count_ff + 5'd1;

   // ---------------------------------------------------------------
   // Sequencer: idle -> 32 conversion steps -> 8 digit transactions
   // ---------------------------------------------------------------
   always_comb begin
      state_in         = state_ff;
      step_in          = step_ff;
      pos_in           = pos_ff;
      req_bus.ready    = 1'b0;
      rsp_bus.valid    = 1'b0;
      bcd_ctrl.load    = 1'b0;
      bcd_ctrl.step    = 1'b0;
      unique case (state_ff)
         ssdf_pkg::ST_IDLE: begin
            // hold off requests while reset is asserted
            req_bus.ready = !reset;
            if (req_bus.valid && !reset) begin
               bcd_ctrl.load = 1'b1;
               step_in       = '0;
               state_in      = ssdf_pkg::ST_CONVERT;
            end
         end
         ssdf_pkg::ST_CONVERT: begin
            bcd_ctrl.step = 1'b1;
            step_in       = step_ff + 5'd1;
            if (step_ff == 5'(ssdf_pkg::CONVERT_STEPS - 1)) begin
               pos_in   = '0;
               state_in = ssdf_pkg::ST_EMIT;
            end
         end
         ssdf_pkg::ST_EMIT: begin
            rsp_bus.valid = 1'b1;
            if (rsp_bus.ready) begin
               pos_in = pos_ff + 3'd1;
               if (pos_ff == 3'(ssdf_pkg::DIGIT_COUNT - 1)) begin
                  state_in = ssdf_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ssdf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ssdf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      pos_ff  <= pos_in;
   end

   // ---------------------------------------------------------------
   // Mode state: blink timer, waiting counter, configuration register.
   // Timer and counter update on the accepting edge, the register on a write; the display decision uses the old phase.
   // ---------------------------------------------------------------
   always_comb begin
      blink_interval_in = blink_interval_ff;
      blink_phase_in    = blink_phase_ff;
      last_toggle_in    = last_toggle_ff;
      wait_count_in     = wait_count_ff;
      kind_in           = kind_ff;
      neg_in            = neg_ff;
      big_in            = big_ff;
      show_in           = show_ff;
      dash_upper_in     = dash_upper_ff;

      if (csr_write_enable) begin
         blink_interval_in = csr_write_data;
      end

      if (req_accept) begin
         kind_in       = ssdf_pkg::kind_type'(req_bus.kind);
         neg_in        = req_bus.number[31];
         big_in        = magnitude >= ssdf_pkg::NINE_DIGIT_MIN;
         show_in       = !req_bus.blink_on || !blink_phase_ff;
         dash_upper_in = wait_next > ssdf_pkg::WAIT_HALF;

         if (ssdf_pkg::kind_type'(req_bus.kind) == ssdf_pkg::KIND_WAITING) begin
            wait_count_in = wait_next;
         end

         if (ssdf_pkg::kind_type'(req_bus.kind) == ssdf_pkg::KIND_SIGNED_BLINK) begin
            if (req_bus.blink_on) begin
               // toggle once the interval has strictly passed, wrap-safe
               if (elapsed > {16'd0, blink_interval_ff}) begin
                  blink_phase_in = !blink_phase_ff;
                  last_toggle_in = req_bus.now_ms;
               end
            end else begin
               blink_phase_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blink_interval_ff <= ssdf_pkg::BLINK_RESET_MS;
         blink_phase_ff    <= 1'b0;
         last_toggle_ff    <= '0;
         wait_count_ff     <= '0;
      end else begin
         blink_interval_ff <= blink_interval_in;
         blink_phase_ff    <= blink_phase_in;
         last_toggle_ff    <= last_toggle_in;
         wait_count_ff     <= wait_count_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      neg_ff        <= neg_in;
      big_ff        <= big_in;
      show_ff       <= show_in;
      dash_upper_ff <= dash_upper_in;
   end

   // ---------------------------------------------------------------
   // Serial BCD converters: all three run in lockstep over 32 steps.
   // Count and grams are zero-extended so the leading zeros shift in first.
   // ---------------------------------------------------------------
   ssdf_bcd_serial #(
      .DIGITS (8)
   ) u_num_bcd (
      .clock  (clock),
      .ctrl   (bcd_ctrl),
      .value  (magnitude),
      .digits (num_digits)
   );

   ssdf_bcd_serial #(
      .DIGITS (3)
   ) u_count_bcd (
      .clock  (clock),
      .ctrl   (bcd_ctrl),
      .value  ({16'd0, req_bus.count}),
      .digits (count_digits)
   );

   ssdf_bcd_serial #(
      .DIGITS (3)
   ) u_grams_bcd (
      .clock  (clock),
      .ctrl   (bcd_ctrl),
      .value  ({16'd0, req_bus.grams}),
      .digits (grams_digits)
   );

   // Highest nonzero digit of the signed value, zero when the value is zero,
   // one past the display when the magnitude overflows eight digits.
   always_comb begin
      top_pos = 4'd0;
      for (int i = 0; i < ssdf_pkg::DIGIT_COUNT; i++) begin
         if (num_digits[i] != 4'd0) begin
            top_pos = 4'(i);
         end
      end
      if (big_ff) begin
         top_pos = 4'(ssdf_pkg::DIGIT_COUNT);
      end
   end

   // ---------------------------------------------------------------
   // Digit code for the current position
   // ---------------------------------------------------------------
   always_comb begin
      code = ssdf_pkg::CODE_BLANK;
      unique case (kind_ff)
         ssdf_pkg::KIND_PLAIN: begin
            code = num_digits[pos_ff];
         end
         ssdf_pkg::KIND_ERROR: begin
            if (!pos_ff[2]) begin
               code = ssdf_pkg::CODE_DASH;
            end else if (pos_ff[1:0] != 2'd3) begin
               code = grams_digits[pos_ff[1:0]];
            end
         end
         ssdf_pkg::KIND_COUNT_GRAMS: begin
            if (pos_ff[1:0] != 2'd3) begin
               code = pos_ff[2] ? count_digits[pos_ff[1:0]] : grams_digits[pos_ff[1:0]];
            end
         end
         ssdf_pkg::KIND_COUNT: begin
            if (!pos_ff[2] && pos_ff[1:0] != 2'd3) begin
               code = count_digits[pos_ff[1:0]];
            end
         end
         ssdf_pkg::KIND_WAITING: begin
            if (pos_ff[2]) begin
               code = dash_upper_ff ? ssdf_pkg::CODE_DASH : ssdf_pkg::CODE_BLANK;
            end else if (pos_ff[1:0] != 2'd3) begin
               code = count_digits[pos_ff[1:0]];
            end
         end
         ssdf_pkg::KIND_DASHES: begin
            code = ssdf_pkg::CODE_DASH;
         end
         ssdf_pkg::KIND_SIGNED_BLINK: begin
            if (show_ff) begin
               if ({1'b0, pos_ff} <= top_pos) begin
                  code = num_digits[pos_ff];
               end else if (neg_ff && ({1'b0, pos_ff} == top_pos + 4'd1)) begin
                  code = ssdf_pkg::CODE_DASH;
               end
            end
         end
         ssdf_pkg::KIND_UNDEFINED: begin
            code = ssdf_pkg::CODE_BLANK;
         end
         default: begin
            code = ssdf_pkg::CODE_BLANK;
         end
      endcase
   end

   assign rsp_bus.position   = pos_ff;
   assign rsp_bus.digit_code = code;
   assign rsp_bus.last       = (pos_ff == 3'(ssdf_pkg::DIGIT_COUNT - 1));

endmodule

`default_nettype wire

// File: test/seven_segment_digit_formatter_tb.sv
// Self-checking testbench for the seven-segment digit formatter: random and directed requests.
`timescale 1ns / 1ps

module seven_segment_digit_formatter_tb;
   import ssdf_pkg::*;

   // Cycles with no transaction on either channel before the run is abandoned.
   localparam int STALL_LIMIT = 4000;

   typedef struct {
      kind_type    kind;
      bit [31:0]   number;
      bit [15:0]   count;
      bit [15:0]   grams;
      bit          blink_on;
      bit [31:0]   now_ms;
   } display_request_type;

   typedef struct {
      bit [2:0]    position;
      digit_type   code;
      bit          last;
   } digit_result_type;

   // Predicts the eight digit transactions of each accepted request and checks
   // the response stream against them, oldest first.
   class digit_scoreboard;
      bit [15:0]          blink_interval;
      bit                 blink_phase;
      bit [31:0]          last_toggle;
      bit [4:0]           wait_count;
      digit_type          shown[DIGIT_COUNT];
      digit_result_type   expected_digits[$];
      int                 failures;

      function new();
         blink_interval = BLINK_RESET_MS;
         blink_phase    = 1'b0;
         last_toggle    = '0;
         wait_count     = '0;
         failures       = 0;
      endfunction

      function void set_interval(bit [15:0] value);
         blink_interval = value;
      endfunction

      function int pending();
         return expected_digits.size();
      endfunction

      function void fill_range(int from, int upto, digit_type code);
         for (int i = from; i < upto; i++) shown[i] = code;
      endfunction

      // Three low decimal digits of a value, starting at a base position.
      function void put_three(int base, bit [31:0] value);
         bit [31:0] v;
         v = value;
         for (int i = 0; i < 3; i++) begin
            shown[(base + i) % DIGIT_COUNT] = digit_type'(v % 10);
            v = v / 10;
         end
      endfunction

      function void accept_request(display_request_type r);
         bit [31:0]        mag;
         bit               negative;
         int               top;
         digit_result_type d;
         negative = r.number[31];
         mag = negative ? (~r.number + 32'd1) : r.number;
         fill_range(0, DIGIT_COUNT, CODE_BLANK);
         case (r.kind)
            KIND_PLAIN: begin
               for (int i = 0; i < DIGIT_COUNT; i++) begin
                  shown[i] = digit_type'(mag % 10);
                  mag = mag / 10;
               end
            end
            KIND_ERROR: begin
               fill_range(0, 4, CODE_DASH);
               put_three(4, {16'd0, r.grams});
            end
            KIND_COUNT_GRAMS: begin
               put_three(0, {16'd0, r.grams});
               put_three(4, {16'd0, r.count});
            end
            KIND_COUNT: put_three(0, {16'd0, r.count});
            KIND_WAITING: begin
               // Step the wrap counter first; the upper half dashes past the midpoint.
               wait_count = wait_count + 5'd1;
               if (wait_count > WAIT_WRAP) wait_count = '0;
               if (wait_count > WAIT_HALF) fill_range(4, DIGIT_COUNT, CODE_DASH);
               put_three(0, {16'd0, r.count});
            end
            KIND_DASHES: fill_range(0, DIGIT_COUNT, CODE_DASH);
            KIND_SIGNED_BLINK: begin
               if (!r.blink_on || !blink_phase) begin
                  top = DIGIT_COUNT;
                  for (int i = 0; i < DIGIT_COUNT; i++) begin
                     shown[i] = digit_type'(mag % 10);
                     mag = mag / 10;
                     if (mag == 0) begin
                        top = i;
                        break;
                     end
                  end
                  if (negative && top + 1 < DIGIT_COUNT) shown[top + 1] = CODE_DASH;
               end
               if (r.blink_on) begin
                  if (r.now_ms - last_toggle > {16'd0, blink_interval}) begin
                     blink_phase = ~blink_phase;
                     last_toggle = r.now_ms;
                  end
               end else begin
                  blink_phase = 1'b0;
               end
            end
            default: ;
         endcase
         for (int i = 0; i < DIGIT_COUNT; i++) begin
            d.position = 3'(i);
            d.code     = shown[i];
            d.last     = (i == DIGIT_COUNT - 1);
            expected_digits.push_back(d);
         end
      endfunction

      function void check_digit(bit [2:0] position, digit_type code, bit last);
         digit_result_type want;
         if (expected_digits.size() == 0) begin
            $display("%0t: unexpected digit: position %0d code %0d last %0d",
                     $time, position, code, last);
            failures++;
            return;
         end
         want = expected_digits.pop_front();
         if (want.position != position || want.code != code || want.last != last) begin
            $display({"%0t: digit mismatch: expected position %0d code %0d last %0d,",
                      " got position %0d code %0d last %0d"},
                     $time, want.position, want.code, want.last, position, code, last);
            failures++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [15:0] csr_write_data;

   ssdf_req_if req_bus();
   ssdf_rsp_if rsp_bus();

   digit_scoreboard sb = new();

   bit        quiet_period;   // suspend idling on both sides while set
   bit [31:0] ms_now;         // millisecond clock the stimulus walks forward
   int        idle_cycles;

   seven_segment_digit_formatter dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Response side: stall at random unless a quiet period is running.
   always @(negedge clock) begin
      rsp_bus.ready <= quiet_period || ($urandom_range(0, 99) >= 25);
   end

   // Check every accepted digit transaction against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_digit(rsp_bus.position, rsp_bus.digit_code, rsp_bus.last);
   end

   // Watchdog: abandon the run once no transaction has moved for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // Offer one request at the falling edge and hold it until it is taken.
   // Leave valid high afterwards; the next call replaces it or stop_requests drops it.
   task automatic send_request(input display_request_type r);
      if (!quiet_period && $urandom_range(0, 99) < 25) begin
         req_bus.valid = 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_bus.valid    = 1'b1;
      req_bus.kind     = r.kind;
      req_bus.number   = r.number;
      req_bus.count    = r.count;
      req_bus.grams    = r.grams;
      req_bus.blink_on = r.blink_on;
      req_bus.now_ms   = r.now_ms;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.accept_request(r);
      @(negedge clock);
   endtask

   task automatic send_fields(input kind_type kind, input bit [31:0] number,
                              input bit [15:0] count, input bit [15:0] grams,
                              input bit blink_on, input bit [31:0] now_ms);
      display_request_type r;
      r = '{kind, number, count, grams, blink_on, now_ms};
      send_request(r);
   endtask

   task automatic stop_requests();
      req_bus.valid = 1'b0;
   endtask

   // Hold off the sender until every predicted digit has been seen.
   task automatic wait_for_drain();
      stop_requests();
      while (sb.pending() != 0) @(negedge clock);
   endtask

   // Write the blink interval only while the block is idle.
   task automatic write_interval(input bit [15:0] value);
      wait_for_drain();
      csr_write_enable = 1'b1;
      csr_write_data   = value;
      sb.set_interval(value);
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // Magnitudes spread over every digit count, either sign, plus the odd raw word.
   function automatic bit [31:0] random_number();
      longint lo;
      longint hi;
      int     n;
      bit [31:0] mag;
      case ($urandom_range(0, 9))
         0: return $urandom();
         1: return 32'h8000_0000;
         default: begin
            n  = $urandom_range(1, 10);
            lo = (n == 1) ? 0 : 64'd10 ** (n - 1);
            hi = 64'd10 ** n - 1;
            if (hi > 64'd2147483647) hi = 64'd2147483647;
            mag = $urandom_range(32'(hi), 32'(lo));
            return $urandom_range(0, 1) ? (~mag + 32'd1) : mag;
         end
      endcase
   endfunction

   function automatic bit [15:0] random_small();
      case ($urandom_range(0, 9))
         0: return 16'd0;
         1: return 16'hFFFF;
         2, 3, 4: return 16'($urandom_range(0, 999));
         default: return 16'($urandom());
      endcase
   endfunction

   // Advance the millisecond clock in steps around the blink interval, with
   // an occasional jump anywhere (wrap included).
   function automatic display_request_type random_request(input kind_type kind);
      display_request_type r;
      if ($urandom_range(0, 19) == 0)
         ms_now = $urandom();
      else
         ms_now = ms_now + $urandom_range(0, 2 * int'(sb.blink_interval) + 2);
      r.kind     = kind;
      r.number   = random_number();
      r.count    = random_small();
      r.grams    = random_small();
      r.blink_on = ($urandom_range(0, 99) < 85);
      r.now_ms   = ms_now;
      return r;
   endfunction

   // Bursts of one kind: long waiting runs to reach the wrap, blink runs to walk
   // the phase, short runs of the rest.
   task automatic random_phase(input int items);
      int       sent;
      int       burst;
      int       pick;
      kind_type kind;
      sent = 0;
      while (sent < items) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            kind  = KIND_SIGNED_BLINK;
            burst = $urandom_range(2, 12);
         end else if (pick < 50) begin
            kind  = KIND_WAITING;
            burst = $urandom_range(1, 34);
         end else if (pick < 53) begin
            kind  = KIND_UNDEFINED;
            burst = 1;
         end else begin
            kind  = kind_type'($urandom_range(0, 5));
            burst = $urandom_range(1, 3);
         end
         for (int j = 0; j < burst && sent < items; j++) begin
            send_request(random_request(kind));
            sent++;
         end
      end
   endtask

   initial begin
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      req_bus.valid    = 1'b0;
      req_bus.kind     = '0;
      req_bus.number   = '0;
      req_bus.count    = '0;
      req_bus.grams    = '0;
      req_bus.blink_on = 1'b0;
      req_bus.now_ms   = '0;
      rsp_bus.ready    = 1'b0;
      quiet_period     = 1'b0;
      ms_now           = '0;
      idle_cycles      = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: field extremes and every kind under the reset interval.
      send_fields(KIND_PLAIN, 32'd0, 16'd0, 16'd0, 1'b0, 32'd0);
      send_fields(KIND_PLAIN, 32'd99999999, 16'hFFFF, 16'hFFFF, 1'b1, 32'd0);
      send_fields(KIND_PLAIN, -32'sd12345678, 16'd0, 16'd0, 1'b0, 32'd0);
      send_fields(KIND_PLAIN, 32'h8000_0000, 16'd0, 16'd0, 1'b0, 32'd0);
      send_fields(KIND_PLAIN, 32'h7FFF_FFFF, 16'd0, 16'd0, 1'b0, 32'd0);
      send_fields(KIND_ERROR, 32'd0, 16'd0, 16'hFFFF, 1'b0, 32'd0);
      send_fields(KIND_COUNT_GRAMS, 32'd0, 16'hFFFF, 16'd12345, 1'b0, 32'd0);
      send_fields(KIND_COUNT, 32'd0, 16'd999, 16'd0, 1'b0, 32'd0);
      send_fields(KIND_WAITING, 32'd0, 16'd123, 16'd0, 1'b0, 32'd0);
      send_fields(KIND_DASHES, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
      send_fields(KIND_UNDEFINED, 32'd5, 16'd5, 16'd5, 1'b1, 32'd5000);
      // Signed blink, blinking off: zero, minus sign placement, no room for a sign.
      send_fields(KIND_SIGNED_BLINK, 32'd0, 16'd0, 16'd0, 1'b0, 32'd0);
      send_fields(KIND_SIGNED_BLINK, -32'sd5, 16'd0, 16'd0, 1'b0, 32'd0);
      send_fields(KIND_SIGNED_BLINK, -32'sd1234567, 16'd0, 16'd0, 1'b0, 32'd0);
      send_fields(KIND_SIGNED_BLINK, -32'sd12345678, 16'd0, 16'd0, 1'b0, 32'd0);
      send_fields(KIND_SIGNED_BLINK, 32'h8000_0000, 16'd0, 16'd0, 1'b0, 32'd0);
      send_fields(KIND_SIGNED_BLINK, 32'd123456789, 16'd0, 16'd0, 1'b0, 32'd0);
      // Blinking on: elapsed equal to the interval holds, one more toggles.
      send_fields(KIND_SIGNED_BLINK, 32'd42, 16'd0, 16'd0, 1'b1, 32'd500);
      send_fields(KIND_SIGNED_BLINK, 32'd42, 16'd0, 16'd0, 1'b1, 32'd501);
      send_fields(KIND_SIGNED_BLINK, 32'd42, 16'd0, 16'd0, 1'b1, 32'd600);
      send_fields(KIND_SIGNED_BLINK, 32'd42, 16'd0, 16'd0, 1'b1, 32'd1002);
      send_fields(KIND_SIGNED_BLINK, -32'sd7, 16'd0, 16'd0, 1'b1, 32'd1002);
      send_fields(KIND_SIGNED_BLINK, 32'd8, 16'd0, 16'd0, 1'b0, 32'd1002);
      ms_now = 32'd1002;

      random_phase(20);
      // Pause the sender until the pipeline is empty, then carry on.
      wait_for_drain();
      random_phase(15);

      // Zero interval: no elapsed time holds the phase, one millisecond toggles.
      write_interval(16'd0);
      send_fields(KIND_SIGNED_BLINK, 32'd31, 16'd0, 16'd0, 1'b1, sb.last_toggle);
      send_fields(KIND_SIGNED_BLINK, 32'd31, 16'd0, 16'd0, 1'b1, sb.last_toggle + 32'd1);
      random_phase(25);

      write_interval(16'hFFFF);
      quiet_period = 1'b1;
      random_phase(30);
      quiet_period = 1'b0;

      write_interval(16'd1);
      random_phase(25);

      write_interval(16'($urandom_range(2, 4000)));
      random_phase(30);

      wait_for_drain();
      repeat (50) @(negedge clock);
      if (sb.failures == 0 && sb.pending() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
